FILE: hdl/jst_pkg.sv
`default_nettype none
package jst_pkg;

  // Parser modes.
  typedef enum logic [3:0] {
    M_WAIT      = 4'd0,
    M_OBJ       = 4'd1,
    M_ARR       = 4'd2,
    M_END_KEY   = 4'd3,
    M_AFTER_KEY = 4'd4,
    M_AFTER_VAL = 4'd5,
    M_STR       = 4'd6,
    M_ESC       = 4'd7,
    M_UNI       = 4'd8,
    M_NUM       = 4'd9,
    M_TRUE      = 4'd10,
    M_FALSE     = 4'd11,
    M_NULL      = 4'd12
  } mode_t;

  // Nesting stack entry kinds.
  localparam logic [1:0] S_OBJ = 2'd0;
  localparam logic [1:0] S_ARR = 2'd1;
  localparam logic [1:0] S_KEY = 2'd2;
  localparam logic [1:0] S_STR = 2'd3;

  // Event kinds.
  localparam logic [3:0] EV_STARTDOC = 4'd0;
  localparam logic [3:0] EV_STARTOBJ = 4'd1;
  localparam logic [3:0] EV_ENDOBJ   = 4'd2;
  localparam logic [3:0] EV_STARTARR = 4'd3;
  localparam logic [3:0] EV_ENDARR   = 4'd4;
  localparam logic [3:0] EV_KEYCHAR  = 4'd5;
  localparam logic [3:0] EV_KEYEND   = 4'd6;
  localparam logic [3:0] EV_STRCHAR  = 4'd7;
  localparam logic [3:0] EV_STREND   = 4'd8;
  localparam logic [3:0] EV_NUMCHAR  = 4'd9;
  localparam logic [3:0] EV_NUMEND   = 4'd10;
  localparam logic [3:0] EV_TRUE     = 4'd11;
  localparam logic [3:0] EV_FALSE    = 4'd12;
  localparam logic [3:0] EV_NULL     = 4'd13;
  localparam logic [3:0] EV_ENDDOC   = 4'd14;
  localparam logic [3:0] EV_ERROR    = 4'd15;

  // Error codes.
  localparam logic [4:0] E_CTRL     = 5'd0;
  localparam logic [4:0] E_KEYEXP   = 5'd1;
  localparam logic [4:0] E_COLON    = 5'd2;
  localparam logic [4:0] E_OBJSEP   = 5'd3;
  localparam logic [4:0] E_ARRSEP   = 5'd4;
  localparam logic [4:0] E_DOT2     = 5'd5;
  localparam logic [4:0] E_DOTEXP   = 5'd6;
  localparam logic [4:0] E_EXP2     = 5'd7;
  localparam logic [4:0] E_SIGN     = 5'd8;
  localparam logic [4:0] E_STREND   = 5'd9;
  localparam logic [4:0] E_VALUE    = 5'd10;
  localparam logic [4:0] E_ARRCLOSE = 5'd11;
  localparam logic [4:0] E_OBJCLOSE = 5'd12;
  localparam logic [4:0] E_ESC      = 5'd13;
  localparam logic [4:0] E_HEX      = 5'd14;
  localparam logic [4:0] E_TRUE     = 5'd15;
  localparam logic [4:0] E_FALSE    = 5'd16;
  localparam logic [4:0] E_NULL     = 5'd17;
  localparam logic [4:0] E_OVERFLOW = 5'd18;

  localparam logic [12:0] LIMIT_MAX = 13'd4096;

  // One result item.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] ch;
    logic [4:0] err;
    logic       trunc;
  } ev_t;

  // Up to three result items caused by one byte.
  typedef struct packed {
    logic [1:0] cnt;
    ev_t        e2;
    ev_t        e1;
    ev_t        e0;
  } evset_t;

  function automatic ev_t mk_ev(logic [3:0] k, logic [7:0] c, logic [4:0] e, logic t);
    ev_t r;
    r.kind = k;
    r.ch = c;
    r.err = e;
    r.trunc = t;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/jst_core.sv
`default_nettype none
module jst_core #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      byte_in,
  input  wire logic [12:0]     limit,
  output jst_pkg::evset_t      evs
);
  import jst_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(STACK_DEPTH);

  mode_t           mode_r, mode_nxt;
  logic [1:0]      stack_r [STACK_DEPTH];
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [12:0]     tlen_r, tlen_nxt;
  logic [2:0]      nflags_r, nflags_nxt;
  logic [3:0]      lit_r, lit_nxt;
  logic [15:0]     hex_r, hex_nxt;
  logic [2:0]      hcnt_r, hcnt_nxt;
  logic            push_en;
  logic [1:0]      push_val;
  logic [1:0]      top_v;
  logic [12:0]     elim;
  logic [AW-1:0]   top_idx;

  assign elim = (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
  assign top_idx = AW'(depth_r - DW'(1));
  assign top_v = (depth_r == '0) ? S_OBJ : stack_r[top_idx];

  // Byte handling; a number terminator is reprocessed in the same cycle.
  always_comb begin
    logic [7:0] c;
    logic ws, redo, lbad, dohex;
    logic [2:0] lpos, llen;
    logic [7:0] lexp, code;
    logic [3:0] hv;
    logic [15:0] hacc;
    int n;
    ev_t ev [3];
    c = byte_in;
    mode_nxt = mode_r;
    depth_nxt = depth_r;
    tlen_nxt = tlen_r;
    nflags_nxt = nflags_r;
    lit_nxt = lit_r;
    hex_nxt = hex_r;
    hcnt_nxt = hcnt_r;
    push_en = 1'b0;
    push_val = S_OBJ;
    n = 0;
    ev[0] = '0;
    ev[1] = '0;
    ev[2] = '0;
    redo = 1'b0;
    lbad = 1'b0;
    lpos = '0;
    llen = 3'd4;
    lexp = '0;
    code = '0;
    hv = '0;
    hacc = '0;
    dohex = 1'b0;
    ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);

    // Number character or terminator.
    if (mode_r == M_NUM) begin
      if (c >= "0" && c <= "9") begin
        nflags_nxt = nflags_r & 3'b011;
        if (tlen_r < elim) begin ev[n] = mk_ev(EV_NUMCHAR, c, '0, 1'b0); n++; end
        if (tlen_r <= elim) tlen_nxt = tlen_r + 13'd1;
      end else if (c == ".") begin
        if (nflags_r[0]) begin ev[n] = mk_ev(EV_ERROR, '0, E_DOT2, 1'b0); n++; end
        else if (nflags_r[1]) begin ev[n] = mk_ev(EV_ERROR, '0, E_DOTEXP, 1'b0); n++; end
        else begin
          nflags_nxt = (nflags_r | 3'b001) & 3'b011;
          if (tlen_r < elim) begin ev[n] = mk_ev(EV_NUMCHAR, c, '0, 1'b0); n++; end
          if (tlen_r <= elim) tlen_nxt = tlen_r + 13'd1;
        end
      end else if (c == "e" || c == "E") begin
        if (nflags_r[1]) begin ev[n] = mk_ev(EV_ERROR, '0, E_EXP2, 1'b0); n++; end
        else begin
          nflags_nxt = nflags_r | 3'b110;
          if (tlen_r < elim) begin ev[n] = mk_ev(EV_NUMCHAR, c, '0, 1'b0); n++; end
          if (tlen_r <= elim) tlen_nxt = tlen_r + 13'd1;
        end
      end else if (c == "+" || c == "-") begin
        if (!nflags_r[2]) begin ev[n] = mk_ev(EV_ERROR, '0, E_SIGN, 1'b0); n++; end
        else begin
          nflags_nxt = nflags_r & 3'b011;
          if (tlen_r < elim) begin ev[n] = mk_ev(EV_NUMCHAR, c, '0, 1'b0); n++; end
          if (tlen_r <= elim) tlen_nxt = tlen_r + 13'd1;
        end
      end else begin
        ev[n] = mk_ev(EV_NUMEND, '0, '0, tlen_r > elim); n++;
        tlen_nxt = '0;
        nflags_nxt = '0;
        mode_nxt = M_AFTER_VAL;
        redo = 1'b1;
      end
    end

    // Structural handling, also for a reprocessed terminator.
    if (redo || mode_r != M_NUM) begin
      if (!(redo && ws) && !(ws && (mode_nxt == M_OBJ || mode_nxt == M_ARR ||
          mode_nxt == M_END_KEY || mode_nxt == M_AFTER_KEY || mode_nxt == M_AFTER_VAL))) begin
        case (mode_nxt)
          M_OBJ: begin
            if (c == "}") begin
              if (depth_r == '0 || top_v != S_OBJ) begin
                ev[n] = mk_ev(EV_ERROR, '0, E_OBJCLOSE, 1'b0); n++;
              end else begin
                depth_nxt = depth_r - DW'(1);
                ev[n] = mk_ev(EV_ENDOBJ, '0, '0, 1'b0); n++;
                mode_nxt = M_AFTER_VAL;
                if (depth_nxt == '0) begin ev[n] = mk_ev(EV_ENDDOC, '0, '0, 1'b0); n++; end
              end
            end else if (c == "\"") begin
              if (depth_r >= DMAX) begin ev[n] = mk_ev(EV_ERROR, '0, E_OVERFLOW, 1'b0); n++; end
              else begin
                push_en = 1'b1; push_val = S_KEY; depth_nxt = depth_r + DW'(1);
                mode_nxt = M_STR; tlen_nxt = '0; nflags_nxt = '0;
              end
            end else begin
              ev[n] = mk_ev(EV_ERROR, '0, E_KEYEXP, 1'b0); n++;
            end
          end
          M_END_KEY: begin
            if (c == ":") mode_nxt = M_AFTER_KEY;
            else begin ev[n] = mk_ev(EV_ERROR, '0, E_COLON, 1'b0); n++; end
          end
          M_ARR, M_AFTER_KEY, M_AFTER_VAL: begin
            if ((mode_nxt == M_ARR && c == "]") ||
                (mode_nxt == M_AFTER_VAL && top_v == S_ARR && c == "]")) begin
              if (depth_r == '0 || top_v != S_ARR) begin
                ev[n] = mk_ev(EV_ERROR, '0, E_ARRCLOSE, 1'b0); n++;
              end else begin
                depth_nxt = depth_r - DW'(1);
                ev[n] = mk_ev(EV_ENDARR, '0, '0, 1'b0); n++;
                mode_nxt = M_AFTER_VAL;
                if (depth_nxt == '0) begin ev[n] = mk_ev(EV_ENDDOC, '0, '0, 1'b0); n++; end
              end
            end else if (mode_nxt == M_AFTER_VAL && top_v != S_ARR && c == "}") begin
              if (depth_r == '0) begin
                ev[n] = mk_ev(EV_ERROR, '0, E_OBJCLOSE, 1'b0); n++;
              end else begin
                depth_nxt = depth_r - DW'(1);
                ev[n] = mk_ev(EV_ENDOBJ, '0, '0, 1'b0); n++;
                mode_nxt = M_AFTER_VAL;
                if (depth_nxt == '0) begin ev[n] = mk_ev(EV_ENDDOC, '0, '0, 1'b0); n++; end
              end
            end else if (mode_nxt == M_AFTER_VAL) begin
              if (c == ",") mode_nxt = (top_v == S_ARR) ? M_ARR : M_OBJ;
              else begin
                ev[n] = mk_ev(EV_ERROR, '0, (top_v == S_ARR) ? E_ARRSEP : E_OBJSEP, 1'b0);
                n++;
              end
            end else if (c == "[" || c == "{" || c == "\"") begin
              if (depth_r >= DMAX) begin ev[n] = mk_ev(EV_ERROR, '0, E_OVERFLOW, 1'b0); n++; end
              else begin
                push_en = 1'b1;
                depth_nxt = depth_r + DW'(1);
                if (c == "[") begin
                  push_val = S_ARR; ev[n] = mk_ev(EV_STARTARR, '0, '0, 1'b0); n++;
                  mode_nxt = M_ARR;
                end else if (c == "{") begin
                  push_val = S_OBJ; ev[n] = mk_ev(EV_STARTOBJ, '0, '0, 1'b0); n++;
                  mode_nxt = M_OBJ;
                end else begin
                  push_val = S_STR; mode_nxt = M_STR; tlen_nxt = '0; nflags_nxt = '0;
                end
              end
            end else if ((c >= "0" && c <= "9") || c == "-") begin
              mode_nxt = M_NUM; nflags_nxt = '0;
              if (elim != '0) begin ev[n] = mk_ev(EV_NUMCHAR, c, '0, 1'b0); n++; end
              tlen_nxt = 13'd1;
            end else if (c == "t" || c == "f" || c == "n") begin
              mode_nxt = (c == "t") ? M_TRUE : ((c == "f") ? M_FALSE : M_NULL);
              lit_nxt = 4'd1;
            end else begin
              ev[n] = mk_ev(EV_ERROR, '0, E_VALUE, 1'b0); n++;
            end
          end
          M_STR: begin
            if (c == "\"") begin
              if (depth_r == '0 || (top_v != S_KEY && top_v != S_STR)) begin
                ev[n] = mk_ev(EV_ERROR, '0, E_STREND, 1'b0); n++;
              end else begin
                depth_nxt = depth_r - DW'(1);
                ev[n] = mk_ev((top_v == S_KEY) ? EV_KEYEND : EV_STREND, '0, '0,
                              tlen_r > elim);
                n++;
                tlen_nxt = '0;
                mode_nxt = (top_v == S_KEY) ? M_END_KEY : M_AFTER_VAL;
              end
            end else if (c == "\\") mode_nxt = M_ESC;
            else if (c <= 8'h1F || c == 8'h7F) begin
              ev[n] = mk_ev(EV_ERROR, '0, E_CTRL, 1'b0); n++;
            end else begin
              code = c; dohex = 1'b1;
            end
          end
          M_ESC: begin
            dohex = 1'b1;
            case (c)
              "\"", "\\", "/": code = c;
              "b": code = 8'h08;
              "f": code = 8'h0C;
              "n": code = 8'h0A;
              "r": code = 8'h0D;
              "t": code = 8'h09;
              "u": begin
                dohex = 1'b0; mode_nxt = M_UNI; hex_nxt = '0; hcnt_nxt = '0;
              end
              default: begin
                dohex = 1'b0; ev[n] = mk_ev(EV_ERROR, '0, E_ESC, 1'b0); n++;
              end
            endcase
          end
          M_UNI: begin
            if (c >= "0" && c <= "9") hv = 4'(c - "0");
            else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
            if ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                (c >= "A" && c <= "F")) begin
              hacc = {hex_r[11:0], hv};
              hex_nxt = hacc;
              hcnt_nxt = hcnt_r + 3'd1;
              if (hcnt_r >= 3'd3) begin
                hex_nxt = '0; hcnt_nxt = '0; dohex = 1'b1;
                code = (hacc <= 16'h007F) ? hacc[7:0] : 8'h20;
              end
            end else begin
              ev[n] = mk_ev(EV_ERROR, '0, E_HEX, 1'b0); n++;
            end
          end
          M_TRUE, M_FALSE, M_NULL: begin
            lpos = lit_r[2:0];
            lbad = lit_r[3];
            if (mode_nxt == M_FALSE) llen = 3'd5;
            case (mode_nxt)
              M_TRUE: case (lpos)
                3'd0: lexp = "t"; 3'd1: lexp = "r"; 3'd2: lexp = "u";
                3'd3: lexp = "e"; default: lexp = '0;
              endcase
              M_FALSE: case (lpos)
                3'd0: lexp = "f"; 3'd1: lexp = "a"; 3'd2: lexp = "l";
                3'd3: lexp = "s"; 3'd4: lexp = "e"; default: lexp = '0;
              endcase
              default: case (lpos)
                3'd0: lexp = "n"; 3'd1: lexp = "u"; 3'd2: lexp = "l";
                3'd3: lexp = "l"; default: lexp = '0;
              endcase
            endcase
            if (lpos >= llen || c != lexp) lbad = 1'b1;
            lpos = lpos + 3'd1;
            if (lpos >= llen) begin
              if (lbad) begin
                ev[n] = mk_ev(EV_ERROR, '0, (mode_nxt == M_TRUE) ? E_TRUE :
                              ((mode_nxt == M_FALSE) ? E_FALSE : E_NULL), 1'b0);
                n++;
              end else begin
                ev[n] = mk_ev((mode_nxt == M_TRUE) ? EV_TRUE :
                              ((mode_nxt == M_FALSE) ? EV_FALSE : EV_NULL), '0, '0, 1'b0);
                n++;
                lit_nxt = '0;
                mode_nxt = M_AFTER_VAL;
              end
            end else lit_nxt = {lbad, lpos};
          end
          default: begin
            if (c == "{") begin
              ev[n] = mk_ev(EV_STARTDOC, '0, '0, 1'b0); n++;
              ev[n] = mk_ev(EV_STARTOBJ, '0, '0, 1'b0); n++;
              push_en = 1'b1; push_val = S_OBJ;
              depth_nxt = DW'(1);
              mode_nxt = M_OBJ;
              tlen_nxt = '0; nflags_nxt = '0; lit_nxt = '0; hex_nxt = '0; hcnt_nxt = '0;
            end
          end
        endcase
        // String character into key or string.
        if (dohex) begin
          if (tlen_r < elim) begin
            ev[n] = mk_ev((top_v == S_KEY) ? EV_KEYCHAR : EV_STRCHAR, code, '0, 1'b0);
            n++;
          end
          if (tlen_r <= elim) tlen_nxt = tlen_r + 13'd1;
          mode_nxt = M_STR;
        end
      end
    end

    // Errors and document end restart the parser.
    if (n > 0 && (ev[n-1].kind == EV_ERROR || ev[n-1].kind == EV_ENDDOC)) begin
      mode_nxt = M_WAIT; depth_nxt = '0; tlen_nxt = '0; nflags_nxt = '0;
      lit_nxt = '0; hex_nxt = '0; hcnt_nxt = '0; push_en = 1'b0;
    end
    evs.cnt = 2'(n);
    evs.e0 = ev[0];
    evs.e1 = ev[1];
    evs.e2 = ev[2];
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_WAIT;
      depth_r <= '0;
      tlen_r <= '0;
      nflags_r <= '0;
      lit_r <= '0;
      hex_r <= '0;
      hcnt_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      depth_r <= depth_nxt;
      tlen_r <= tlen_nxt;
      nflags_r <= nflags_nxt;
      lit_r <= lit_nxt;
      hex_r <= hex_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  // Nesting stack; a push writes at the old depth.
  always_ff @(posedge clk) begin
    if (step && push_en) stack_r[AW'(depth_nxt - DW'(1))] <= push_val;
  end

  a_depth: assert property (@(posedge clk) disable iff (!rst_n) depth_r <= DMAX)
    else $error("nesting depth beyond stack");
  a_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_WAIT) |-> (depth_r == '0))
    else $error("depth nonzero while waiting");
  a_hex: assert property (@(posedge clk) disable iff (!rst_n) hcnt_r <= 3'd3)
    else $error("hex count out of range");
endmodule
`default_nettype wire

FILE: hdl/jst_outq.sv
`default_nettype none
module jst_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire jst_pkg::evset_t evs,
  output logic                 busy,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata
);
  import jst_pkg::*;

  evset_t     set_r;
  logic [1:0] idx_r;
  ev_t        cur;
  logic       last;
  logic       adv;

  assign out_tvalid = (set_r.cnt != 2'd0);
  assign cur = (idx_r == 2'd0) ? set_r.e0 : ((idx_r == 2'd1) ? set_r.e1 : set_r.e2);
  assign last = (idx_r + 2'd1 == set_r.cnt);
  assign adv = out_tvalid && out_tready;
  // Can take a new set when empty or when the last item leaves now.
  assign busy = out_tvalid && !(adv && last);
  assign out_tdata = {5'd0, last, cur.trunc, cur.err, cur.ch, cur.kind};

  // Result set register, drained one item per cycle while out_tready is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r.cnt <= '0;
      idx_r <= '0;
    end else if (load) begin
      set_r <= evs;
      idx_r <= '0;
    end else if (adv) begin
      if (last) set_r.cnt <= '0;
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (idx_r < set_r.cnt))
    else $error("index beyond result count");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy)
    else $error("load while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) set_r.cnt != 2'd3 ||
    idx_r <= 2'd2)
    else $error("bad index");
endmodule
`default_nettype wire

FILE: hdl/json_stream_tokenizer_top.sv
// Result items of an accepted byte are registered in the output queue before they are offered.
// Throughput: one byte per cycle when it gives at most one result and out_tready is high; a byte
// giving more results holds the input while the result register drains.
// Reset (rst_n low, synchronous) returns the parser to waiting for the document
// start and sets token_limit to 512.
`default_nettype none
module json_stream_tokenizer_top #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // event_kind, char_out, error_code, truncated, last_result
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata   // token_limit
);
  import jst_pkg::*;

  logic [12:0] limit_r;
  evset_t      evs;
  logic        busy;
  logic        step;

  assign in_tready = !busy;
  assign step = in_tvalid && in_tready;

  // Token limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 13'd512;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  jst_core #(.STACK_DEPTH(STACK_DEPTH)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .byte_in(in_tdata), .limit(limit_r), .evs(evs)
  );

  jst_outq u_outq (
    .clk(clk), .rst_n(rst_n), .load(step), .evs(evs), .busy(busy),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule
`default_nettype wire
